/* rtl/mvt_pkg.sv */
// Package with sizes, request codes and payload types of the valve timer.
`timescale 1ns / 1ps

package mvt_pkg;

  localparam int NUM_SECTIONS = 8;
  localparam int TIMER_BITS = 32;
  localparam int SHOWN_SECTIONS = (NUM_SECTIONS < 8) ? NUM_SECTIONS : 8;

  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_ONE_ON = 3'd1;
  localparam logic [2:0] REQ_ONE_OFF = 3'd2;
  localparam logic [2:0] REQ_MASK_ON = 3'd3;
  localparam logic [2:0] REQ_ALL_OFF = 3'd4;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_BAD_SECTION = 1'b1;

  typedef logic [NUM_SECTIONS-1:0] section_vec_t;
  typedef logic [NUM_SECTIONS-1:0][TIMER_BITS-1:0] counter_bank_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] section_number;
    logic [7:0] section_select_mask;
    logic [31:0] run_seconds;
  } req_beat_t;

  typedef struct packed {
    logic [7:0] active_sections;
    logic master_on;
    logic [7:0] expired_sections;
    logic status;
  } rsp_beat_t;

endpackage

/* rtl/mvt_if.sv */
// Handshake interfaces for the request and result channels of the valve timer.
`timescale 1ns / 1ps

interface mvt_req_if;
  logic valid;
  logic ready;
  logic [2:0] req_type;
  logic [7:0] section_number;
  logic [7:0] section_select_mask;
  logic [31:0] run_seconds;

  modport source (
    output valid, req_type, section_number, section_select_mask, run_seconds,
    input ready
  );
  modport sink (
    input valid, req_type, section_number, section_select_mask, run_seconds,
    output ready
  );
endinterface

interface mvt_rsp_if;
  logic valid;
  logic ready;
  logic [7:0] active_sections;
  logic master_on;
  logic [7:0] expired_sections;
  logic status;

  modport source (
    output valid, active_sections, master_on, expired_sections, status,
    input ready
  );
  modport sink (
    input valid, active_sections, master_on, expired_sections, status,
    output ready
  );
endinterface

/* rtl/multi_section_valve_timer_unit.sv */
// Top level of the multi-section valve timer: request register, section update, result register.
`timescale 1ns / 1ps

// Each request beat produces exactly one result beat, which passes through the
// request register and then the result register. A new request is taken every
// cycle while the result side is not stalled, since all section flags and
// countdown counters update in parallel between the two registers. A tick counts
// down every running section with a nonzero counter and reports the sections that
// reach zero; a duration of zero runs until switched off. A section number outside
// the bank gives status 1 and leaves every section as it was.
module multi_section_valve_timer_unit (
  input logic clk,
  input logic rst,
  mvt_req_if.sink req,
  mvt_rsp_if.source rsp
);

  logic req_full;
  mvt_pkg::req_beat_t req_reg;
  logic rsp_full;
  mvt_pkg::rsp_beat_t rsp_reg;

  mvt_pkg::section_vec_t active;
  mvt_pkg::section_vec_t active_next;
  mvt_pkg::counter_bank_t counters;
  mvt_pkg::counter_bank_t counters_next;
  mvt_pkg::section_vec_t expired_next;
  logic status_next;
  mvt_pkg::rsp_beat_t rsp_next;
  logic advance;

  assign advance = req_full && (!rsp_full || rsp.ready);
  assign req.ready = !req_full || advance;

  always_comb begin
    logic section_ok;
    logic [mvt_pkg::TIMER_BITS-1:0] secs;
    active_next = active;
    counters_next = counters;
    expired_next = '0;
    status_next = mvt_pkg::STATUS_OK;
    secs = req_reg.run_seconds[mvt_pkg::TIMER_BITS-1:0];
    section_ok = (req_reg.section_number >= 8'd1) &&
                 (req_reg.section_number <= 8'(mvt_pkg::NUM_SECTIONS));
    unique case (req_reg.req_type)
      mvt_pkg::REQ_TICK: begin
        for (int i = 0; i < mvt_pkg::NUM_SECTIONS; i++) begin
          if (active[i] && counters[i] != '0) begin
            counters_next[i] = counters[i] - 1'b1;
            if (counters[i] == mvt_pkg::TIMER_BITS'(1)) begin
              active_next[i] = 1'b0;
              expired_next[i] = 1'b1;
            end
          end
        end
      end
      mvt_pkg::REQ_ONE_ON, mvt_pkg::REQ_ONE_OFF: begin
        if (!section_ok) begin
          status_next = mvt_pkg::STATUS_BAD_SECTION;
        end else begin
          for (int i = 0; i < mvt_pkg::NUM_SECTIONS; i++) begin
            if (req_reg.section_number == 8'(i + 1)) begin
              if (req_reg.req_type == mvt_pkg::REQ_ONE_ON) begin
                active_next[i] = 1'b1;
                counters_next[i] = secs;
              end else begin
                active_next[i] = 1'b0;
                counters_next[i] = '0;
              end
            end
          end
        end
      end
      mvt_pkg::REQ_MASK_ON: begin
        for (int i = 0; i < mvt_pkg::SHOWN_SECTIONS; i++) begin
          if (req_reg.section_select_mask[i]) begin
            active_next[i] = 1'b1;
            counters_next[i] = secs;
          end
        end
      end
      mvt_pkg::REQ_ALL_OFF: begin
        active_next = '0;
        counters_next = '0;
      end
      default: begin
      end
    endcase

    rsp_next = '0;
    for (int i = 0; i < mvt_pkg::SHOWN_SECTIONS; i++) begin
      rsp_next.active_sections[i] = active_next[i];
      rsp_next.expired_sections[i] = expired_next[i];
    end
    rsp_next.master_on = (active_next != '0);
    rsp_next.status = status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
      rsp_full <= 1'b0;
      active <= '0;
      counters <= '0;
    end else begin
      if (req.valid && req.ready) begin
        req_full <= 1'b1;
      end else if (advance) begin
        req_full <= 1'b0;
      end
      if (advance) begin
        rsp_full <= 1'b1;
        active <= active_next;
        counters <= counters_next;
      end else if (rsp.ready) begin
        rsp_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_reg.req_type <= req.req_type;
      req_reg.section_number <= req.section_number;
      req_reg.section_select_mask <= req.section_select_mask;
      req_reg.run_seconds <= req.run_seconds;
    end
    if (advance) begin
      rsp_reg <= rsp_next;
    end
  end

  assign rsp.valid = rsp_full;
  assign rsp.active_sections = rsp_reg.active_sections;
  assign rsp.master_on = rsp_reg.master_on;
  assign rsp.expired_sections = rsp_reg.expired_sections;
  assign rsp.status = rsp_reg.status;

  // While a result waits, the section state is the state that result reports.
  a_master_matches_state: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.master_on == (active != '0)))
    else $error("master flag disagrees with section state");

  a_stall_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> ($stable(active) && $stable(counters)))
    else $error("section state changed while a result was stalled");

  a_expired_are_off: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((rsp.expired_sections & rsp.active_sections) == 8'd0))
    else $error("expired section still reported active");

  a_bad_section_no_change: assert property (@(posedge clk) disable iff (rst)
    (advance && status_next == mvt_pkg::STATUS_BAD_SECTION) |=>
      ($stable(active) && $stable(counters)))
    else $error("out of range section number changed state");

endmodule
